>>> src/sda_pkg.sv
package sda_pkg;

    localparam int NUM_STICKS = 2;
    localparam int TIME_WIDTH = 32;
    localparam int DIRS       = 4;
    localparam int MASK_W     = 8;
    localparam int AXIS_W     = 16;
    localparam int THR_W      = 15;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 96;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [AXIS_W-1:0]     axis_t;
    typedef logic [DIRS-1:0]       dir_mask_t;

    // axis centre, one bit wider so centre +/- threshold never wraps
    localparam logic [AXIS_W:0] AXIS_CENTRE = 17'd32768;

    // per direction: up, down, left, right
    localparam dir_mask_t DIR_POSITIVE = 4'b1010;  // down, right need delta > +thr
    localparam dir_mask_t DIR_ON_Y     = 4'b0011;  // up, down read the Y axis

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INITIAL    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD     = 8'd3;

    localparam logic [THR_W-1:0]   RESET_PRESS   = 15'd8192;
    localparam logic [THR_W-1:0]   RESET_RELEASE = 15'd4096;
    localparam logic [DELAY_W-1:0] RESET_INITIAL = 16'd400;
    localparam logic [DELAY_W-1:0] RESET_PERIOD  = 16'd150;

    typedef struct packed {
        logic [THR_W-1:0]   press_thr;
        logic [THR_W-1:0]   release_thr;
        logic [DELAY_W-1:0] repeat_initial;
        logic [DELAY_W-1:0] repeat_period;
    } cfg_t;

    // per-stick lane result
    typedef struct packed {
        dir_mask_t fire;
        dir_mask_t released;
        dir_mask_t pressed;
        dir_mask_t held;
    } lane_res_t;

    // result word, held_mask in the low byte
    typedef struct packed {
        logic [MASK_W-1:0] fire;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] held;
    } res_t;

endpackage

>>> src/stick_direction_autorepeat_unit.sv
// Analog stick to virtual direction unit with hysteresis and auto-repeat.
//
// Input channel (s_*): one transfer per frame carrying the raw X/Y axes of
// two sticks, the frame time in ms (tdata) and the gate flag (tuser). Each
// stick is handled by its own lane; a merge stage packs the four masks into
// one result transfer on the m_* channel.
// Config channel (cfg_*): register writes by index, always ready. Write
// only while the unit is idle. Indexes beyond the register list are dropped.
//
// A frame's result is registered in the output register, or in the skid
// register on a receiver stall. Throughput: one frame per cycle while s_tready
// is high, set by the lane logic (compares and two 32-bit adds per direction).
// Receiver stall: an output register plus a skid register hold up to two
// results; s_tready drops only when both are full and comes back the cycle
// after the output drains.
// Reset (aresetn low, synchronous): direction, repeat-arm state and both
// output stages clear; registers return to 8192 / 4096 / 400 / 150.
module stick_direction_autorepeat_unit
    import sda_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] left_x, [31:16] left_y, [47:32] right_x, [63:48] right_y,
    // [95:64] now_ms
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [0] pad_gated
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] held_mask, [15:8] pressed_mask, [23:16] released_mask,
    // [31:24] fire_mask
    output logic [$bits(res_t)-1:0] m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      s_accept;
    time_t     now;
    axis_t     axis_x [NUM_STICKS];
    axis_t     axis_y [NUM_STICKS];
    lane_res_t lane_res [NUM_STICKS];
    res_t      merged;

    res_t      out_reg;
    logic      out_valid_reg;
    res_t      skid_reg;
    logic      skid_valid_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_thr      <= RESET_PRESS;
            cfg_reg.release_thr    <= RESET_RELEASE;
            cfg_reg.repeat_initial <= RESET_INITIAL;
            cfg_reg.repeat_period  <= RESET_PERIOD;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PRESS_THRESHOLD:   cfg_reg.press_thr      <= cfg_data[THR_W-1:0];
                REG_RELEASE_THRESHOLD: cfg_reg.release_thr    <= cfg_data[THR_W-1:0];
                REG_REPEAT_INITIAL:    cfg_reg.repeat_initial <= cfg_data[DELAY_W-1:0];
                REG_REPEAT_PERIOD:     cfg_reg.repeat_period  <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpack ----------------
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign now      = time_t'(s_tdata[95:64]);

    // sticks past the two on the bus read centred
    always_comb begin
        for (int s = 0; s < NUM_STICKS; s++) begin
            if (s == 0) begin
                axis_x[s] = s_tdata[15:0];
                axis_y[s] = s_tdata[31:16];
            end else if (s == 1) begin
                axis_x[s] = s_tdata[47:32];
                axis_y[s] = s_tdata[63:48];
            end else begin
                axis_x[s] = AXIS_CENTRE[AXIS_W-1:0];
                axis_y[s] = AXIS_CENTRE[AXIS_W-1:0];
            end
        end
    end

    // ---------------- lanes ----------------
    for (genvar s = 0; s < NUM_STICKS; s++) begin : g_lane
        sda_stick_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .accept  (s_accept),
            .gated   (s_tuser),
            .axis_x  (axis_x[s]),
            .axis_y  (axis_y[s]),
            .now     (now),
            .cfg     (cfg_reg),
            .res     (lane_res[s])
        );
    end

    // ---------------- merge ----------------
    // bit stick*4+dir; bits past the mask width are dropped
    always_comb begin
        merged = '0;
        for (int s = 0; s < NUM_STICKS; s++) begin
            for (int d = 0; d < DIRS; d++) begin
                if (s * DIRS + d < MASK_W) begin
                    merged.held[s*DIRS+d]     = lane_res[s].held[d];
                    merged.pressed[s*DIRS+d]  = lane_res[s].pressed[d];
                    merged.released[s*DIRS+d] = lane_res[s].released[d];
                    merged.fire[s*DIRS+d]     = lane_res[s].fire[d];
                end
            end
        end
    end

    // ---------------- output register + skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_reg       <= merged;
                    out_valid_reg <= s_accept;
                end
            end else if (s_accept) begin
                skid_reg       <= merged;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result with the output stage empty");

    a_stall_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid result not moved on output transfer");

endmodule

>>> src/sda_stick_lane.sv
module sda_stick_lane
    import sda_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  logic      gated,
    input  axis_t     axis_x,
    input  axis_t     axis_y,
    input  time_t     now,
    input  cfg_t      cfg,
    output lane_res_t res
);

    dir_mask_t dir_now_reg;
    dir_mask_t armed_reg;
    dir_mask_t armed_next;
    time_t     next_fire_reg [DIRS];
    time_t     next_fire_next [DIRS];

    dir_mask_t raw_on;
    dir_mask_t fresh;
    dir_mask_t fire;

    // hysteresis compare per direction
    always_comb begin
        logic [THR_W-1:0]  thr;
        logic [AXIS_W:0]   axis;
        for (int d = 0; d < DIRS; d++) begin
            thr  = dir_now_reg[d] ? cfg.release_thr : cfg.press_thr;
            axis = DIR_ON_Y[d] ? {1'b0, axis_y} : {1'b0, axis_x};
            if (DIR_POSITIVE[d]) begin
                raw_on[d] = axis > (AXIS_CENTRE + {2'b00, thr});
            end else begin
                raw_on[d] = axis < (AXIS_CENTRE - {2'b00, thr});
            end
        end
        // opposite directions on together cancel
        fresh[0] = raw_on[0] & ~raw_on[1];
        fresh[1] = raw_on[1] & ~raw_on[0];
        fresh[2] = raw_on[2] & ~raw_on[3];
        fresh[3] = raw_on[3] & ~raw_on[2];
    end

    // typematic repeat per direction
    always_comb begin
        for (int d = 0; d < DIRS; d++) begin
            armed_next[d]     = armed_reg[d];
            next_fire_next[d] = next_fire_reg[d];
            fire[d]           = 1'b0;
            if (!fresh[d]) begin
                armed_next[d] = 1'b0;
            end else if (!dir_now_reg[d]) begin
                next_fire_next[d] = now + time_t'(cfg.repeat_initial);
                armed_next[d]     = 1'b1;
                fire[d]           = 1'b1;
            end else if (armed_reg[d] && (now >= next_fire_reg[d])) begin
                next_fire_next[d] = now + time_t'(cfg.repeat_period);
                fire[d]           = 1'b1;
            end
        end
    end

    always_comb begin
        if (gated) begin
            res = '0;
        end else begin
            res.held     = fresh;
            res.pressed  = fresh & ~dir_now_reg;
            res.released = ~fresh & dir_now_reg;
            res.fire     = fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_now_reg <= '0;
            armed_reg   <= '0;
        end else if (accept) begin
            dir_now_reg <= fresh;
            if (!gated) begin
                armed_reg <= armed_next;
            end
        end
    end

    // timestamps are only read while armed, and arming writes them
    always_ff @(posedge aclk) begin
        if (accept && !gated) begin
            for (int d = 0; d < DIRS; d++) begin
                next_fire_reg[d] <= next_fire_next[d];
            end
        end
    end

    a_no_opposite_y: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dir_now_reg[0] && dir_now_reg[1]))
        else $error("up and down held together");

    a_no_opposite_x: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dir_now_reg[2] && dir_now_reg[3]))
        else $error("left and right held together");

    a_armed_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !gated) |=> ((armed_reg & ~dir_now_reg) == '0))
        else $error("repeat armed on a released direction");

    a_fire_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.fire & ~res.held) == '0)
        else $error("fire on a direction not held");

endmodule
